>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lzwd_pkg.sv
// shared constants and controller/datapath interface types for the lz77 window decoder
package lzwd_pkg;

    localparam int MAX_OFFSET_BITS_DEF = 12;
    localparam int MAX_LENGTH_BITS_DEF = 5;
    localparam int MAX_COUNT_BITS      = 14;
    localparam int ACC_W               = 14;
    localparam int LIT_W               = 8;

    localparam logic [3:0] OFFSET_BITS_RST = 4'd12;
    localparam logic [2:0] LENGTH_BITS_RST = 3'd4;
    localparam logic [3:0] COUNT_BITS_RST  = 4'd8;

    typedef enum logic [1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_LENGTH_BITS = 2'd1,
        CFG_COUNT_BITS  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic load_byte;
        logic step_bit;
        logic copy_rd;
        logic copy_wr;
        logic flush;
    } lzwd_cmd_t;

    typedef struct packed {
        logic byte_end;
        logic stream_done;
        logic emit_now;
        logic match_now;
        logic push_ok;
        logic copy_last;
    } lzwd_status_t;

endpackage

>>> hw/rtl/lz77_window_decoder.sv
// top level of the lz77 sliding-window decoder
//
// compressed bytes enter on s_tvalid/s_tready/s_tdata; decoded results leave on
// m_tvalid/m_tready with the byte in m_tdata, flags in m_tuser and m_tlast on the
// final result caused by each input beat. widths N, L, S are set through the
// cfg_valid/cfg_index/cfg_data write port, always ready; the user must write them
// only while the block is idle; the block itself does not enforce it. an input
// beat is accepted, takes eight single-bit steps, sees the end of the beat and is
// closed out; each copied match byte adds a registered read of the history ram
// followed by its write. after the end token a beat takes no bit steps and gives
// no result. a result waits in a holding stage until the next result of its beat
// or its close, since only then is it known whether it is the last of its beat.
// reset clears all control state and returns the widths to their defaults; the
// history reads as zero until written, tracked by write pointer and a wrap flag,
// so no clearing pass is needed. when the receiver stalls, the output register and
// the holding stage fill and the decoder waits; s_tready stays low until the
// current beat is finished.
module lz77_window_decoder
    import lzwd_pkg::*;
#(
    parameter int MAX_OFFSET_BITS = MAX_OFFSET_BITS_DEF,
    parameter int MAX_LENGTH_BITS = MAX_LENGTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] data_valid, [1] end_of_stream
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    lzwd_cmd_t    cmd;
    lzwd_status_t status;

    assign cfg_ready = 1'b1;

    lzwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzwd_datapath #(
        .MAX_OFFSET_BITS (MAX_OFFSET_BITS),
        .MAX_LENGTH_BITS (MAX_LENGTH_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

>>> hw/rtl/lzwd_ram.sv
// generic single-write, single-read ram with registered read data
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/lzwd_ctrl.sv
// sequencing state machine: byte accept, bit steps, history copy, end-of-beat flush
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lzwd_status_t status,
    output lzwd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BITS,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (status.byte_end || status.stream_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!status.emit_now || status.push_ok)
                begin
                    cmd.step_bit = 1'b1;
                    if (status.match_now)
                    begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (status.push_ok)
                begin
                    cmd.copy_wr = 1'b1;
                    state_next  = status.copy_last ? ST_BITS : ST_COPY_RD;
                end
            end
            ST_FLUSH:
            begin
                if (status.push_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/lzwd_datapath.sv
// bit unpacker, field decoder, history window, result holding stage and output register
`include "assert_macros.svh"
module lzwd_datapath
    import lzwd_pkg::*;
#(
    parameter int MAX_OFFSET_BITS = MAX_OFFSET_BITS_DEF,
    parameter int MAX_LENGTH_BITS = MAX_LENGTH_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  lzwd_cmd_t    cmd,
    output lzwd_status_t status,
    input  logic [7:0]   in_data,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic [1:0]   out_user,
    output logic         out_last
);

    localparam int AW    = MAX_OFFSET_BITS;
    localparam int DEPTH = 1 << MAX_OFFSET_BITS;
    localparam int ML_W  = MAX_LENGTH_BITS + 1;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_OFFSET,
        PH_COUNT,
        PH_LITERAL
    } phase_t;

    logic [3:0]       off_bits_reg;
    logic [2:0]       len_bits_reg;
    logic [3:0]       cnt_bits_reg;
    logic [7:0]       byte_reg;
    logic [3:0]       k_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [3:0]       gath_reg;
    phase_t           phase_reg;
    logic [ML_W-1:0]  mlen_reg;
    logic [ACC_W-1:0] lit_reg;
    logic             done_reg;
    logic [AW-1:0]    wp_reg;
    logic             wrap_reg;
    logic [AW-1:0]    dist_reg;
    logic             rd_fill_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_byte_reg;
    logic             pend_dv_reg;
    logic             pend_eos_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [1:0]       out_user_reg;
    logic             out_last_reg;

    logic [3:0]       off_w;
    logic [3:0]       len_w;
    logic [3:0]       cnt_w;
    logic [3:0]       width;
    logic             bit_in;
    logic [ACC_W-1:0] acc_shift;
    logic [3:0]       gath_inc;
    logic             field_done;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] value;
    logic             emit_now;
    logic             lit_done;
    logic             push_ok;
    logic             push;
    logic             move;
    logic [7:0]       copy_byte;
    logic [7:0]       new_byte;
    logic             new_dv;
    logic             new_eos;
    logic             hist_we;
    logic [7:0]       hist_wdata;
    logic [AW-1:0]    raddr;
    logic [7:0]       ram_q;
    logic [AW-1:0]    dist_new;

    // field widths, clamped into their legal ranges
    always_comb
    begin
        if (off_bits_reg == 4'd0)
            off_w = 4'd1;
        else if (off_bits_reg > 4'(MAX_OFFSET_BITS))
            off_w = 4'(MAX_OFFSET_BITS);
        else
            off_w = off_bits_reg;

        if (len_bits_reg == 3'd0)
            len_w = 4'd1;
        else if (len_bits_reg > 3'(MAX_LENGTH_BITS))
            len_w = 4'(MAX_LENGTH_BITS);
        else
            len_w = {1'b0, len_bits_reg};

        if (cnt_bits_reg == 4'd0)
            cnt_w = 4'd1;
        else if (cnt_bits_reg > 4'(MAX_COUNT_BITS))
            cnt_w = 4'(MAX_COUNT_BITS);
        else
            cnt_w = cnt_bits_reg;

        case (phase_reg)
            PH_LENGTH: width = len_w;
            PH_OFFSET: width = off_w;
            PH_COUNT:  width = cnt_w;
            default:   width = 4'(LIT_W);
        endcase
    end

    assign bit_in     = byte_reg[k_reg[2:0]];
    assign acc_shift  = {acc_reg[ACC_W-2:0], bit_in};
    assign gath_inc   = gath_reg + 4'd1;
    assign field_done = gath_inc >= width;
    assign mask       = ACC_W'((ACC_W + 1)'(1) << width) - ACC_W'(1);
    assign value      = acc_shift & mask;
    assign lit_done   = field_done && (phase_reg == PH_LITERAL);
    assign emit_now   = lit_done
                        || (field_done && (phase_reg == PH_COUNT) && (value == '0));
    assign dist_new   = (value == '0) ? AW'((AW + 1)'(1) << off_w) : value[AW-1:0];

    assign push_ok = !pend_valid_reg || !out_valid_reg || out_ready;
    assign push    = (cmd.step_bit && emit_now) || cmd.copy_wr;
    assign move    = (push || cmd.flush) && pend_valid_reg;

    assign status.byte_end    = k_reg[3];
    assign status.stream_done = done_reg;
    assign status.emit_now    = emit_now;
    assign status.match_now   = field_done && (phase_reg == PH_OFFSET);
    assign status.push_ok     = push_ok;
    assign status.copy_last   = mlen_reg == ML_W'(1);

    // bytes never written since reset read as zero
    assign copy_byte = rd_fill_reg ? ram_q : 8'd0;

    always_comb
    begin
        if (cmd.copy_wr)
        begin
            new_byte = copy_byte;
            new_dv   = 1'b1;
            new_eos  = 1'b0;
        end
        else if (lit_done)
        begin
            new_byte = value[7:0];
            new_dv   = 1'b1;
            new_eos  = 1'b0;
        end
        else
        begin
            new_byte = 8'd0;
            new_dv   = 1'b0;
            new_eos  = 1'b1;
        end
    end

    assign hist_we    = (cmd.step_bit && lit_done) || cmd.copy_wr;
    assign hist_wdata = cmd.copy_wr ? copy_byte : value[7:0];
    assign raddr      = wp_reg - dist_reg;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .re    (cmd.copy_rd),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_bits_reg   <= OFFSET_BITS_RST;
            len_bits_reg   <= LENGTH_BITS_RST;
            cnt_bits_reg   <= COUNT_BITS_RST;
            k_reg          <= 4'd8;
            acc_reg        <= '0;
            gath_reg       <= '0;
            phase_reg      <= PH_LENGTH;
            mlen_reg       <= '0;
            lit_reg        <= '0;
            done_reg       <= 1'b0;
            wp_reg         <= '0;
            wrap_reg       <= 1'b0;
            dist_reg       <= '0;
            rd_fill_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_OFFSET_BITS: off_bits_reg <= cfg_data;
                    CFG_LENGTH_BITS: len_bits_reg <= cfg_data[2:0];
                    CFG_COUNT_BITS:  cnt_bits_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (cmd.load_byte)
            begin
                k_reg <= 4'd0;
            end

            if (cmd.step_bit)
            begin
                k_reg <= k_reg + 4'd1;
                if (!field_done)
                begin
                    acc_reg  <= acc_shift;
                    gath_reg <= gath_inc;
                end
                else
                begin
                    acc_reg  <= '0;
                    gath_reg <= '0;
                    case (phase_reg)
                        PH_LENGTH:
                        begin
                            if (value != '0)
                            begin
                                mlen_reg  <= ML_W'(value) + ML_W'(1);
                                phase_reg <= PH_OFFSET;
                            end
                            else
                            begin
                                phase_reg <= PH_COUNT;
                            end
                        end
                        PH_OFFSET:
                        begin
                            dist_reg <= dist_new;
                        end
                        PH_COUNT:
                        begin
                            if (value == '0)
                            begin
                                done_reg  <= 1'b1;
                                phase_reg <= PH_LENGTH;
                            end
                            else
                            begin
                                lit_reg   <= value;
                                phase_reg <= PH_LITERAL;
                            end
                        end
                        default:
                        begin
                            lit_reg <= lit_reg - ACC_W'(1);
                            if (lit_reg == ACC_W'(1))
                            begin
                                phase_reg <= PH_LENGTH;
                            end
                        end
                    endcase
                end
            end

            if (cmd.copy_rd)
            begin
                rd_fill_reg <= wrap_reg || (raddr < wp_reg);
            end

            if (cmd.copy_wr)
            begin
                mlen_reg <= mlen_reg - ML_W'(1);
                if (mlen_reg == ML_W'(1))
                begin
                    phase_reg <= PH_LENGTH;
                end
            end

            if (hist_we)
            begin
                wp_reg <= wp_reg + AW'(1);
                if (wp_reg == '1)
                begin
                    wrap_reg <= 1'b1;
                end
            end

            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= in_data;
        end
        if (push)
        begin
            pend_byte_reg <= new_byte;
            pend_dv_reg   <= new_dv;
            pend_eos_reg  <= new_eos;
        end
        if (move)
        begin
            out_byte_reg <= pend_byte_reg;
            out_user_reg <= {pend_eos_reg, pend_dv_reg};
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    `ASSERT_IMPLY(a_push_has_room, clk, rst_n, push || cmd.flush, push_ok,
                  "held result would be overwritten")
    `ASSERT_IMPLY(a_copy_len_nonzero, clk, rst_n, cmd.copy_wr, mlen_reg != '0,
                  "copy beat with no match length left")
    `ASSERT_IMPLY(a_no_bits_after_end, clk, rst_n, done_reg, !cmd.step_bit,
                  "bits decoded after end of stream")
    `ASSERT_NEXT(a_wp_advance, clk, rst_n, hist_we, wp_reg == $past(wp_reg) + AW'(1),
                 "history pointer did not advance by one")

endmodule
